// ===== rtl/rau_pkg.sv =====
// rau_pkg: shared types, codes and constants of the rational arithmetic unit
// no dependencies; imported by rau_gcd, rau_div, rational_arithmetic_unit_core, its checker and its test
package rau_pkg;

	localparam int WORD_BITS = 32;
	localparam int DW        = 64;
	localparam int DIV_CNT_W = $clog2(DW + 1);
	localparam int SHIFT_W   = $clog2(DW);

	localparam logic [DW-1:0] RES_LIM = DW'(1) << (WORD_BITS - 1);
	localparam logic [32:0]   CAP_LIM = 33'd2147483648;
	localparam logic [32:0]   CAP_SAT = 33'd2147483649;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_MUL = 3'd1;
	localparam logic [2:0] OP_NEG = 3'd2;
	localparam logic [2:0] OP_INV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;
	localparam logic [2:0] OP_CMP = 3'd5;

	localparam logic [1:0] REL_EQ = 2'd0;
	localparam logic [1:0] REL_LT = 2'd1;
	localparam logic [1:0] REL_GT = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_ZDEN = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] a_num;
		logic [30:0]        a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
		logic signed [7:0]  exponent;
	} rau_cmd_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         relation;
		logic [1:0]         status;
	} rau_rsp_t;

	// request to an iterative unit and its answer
	typedef struct packed {
		logic          start;
		logic [DW-1:0] x;
		logic [DW-1:0] y;
	} unit_req_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] value;
	} unit_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RED_G,
		S_RED_GW,
		S_RED_DX,
		S_RED_DXW,
		S_RED_DY,
		S_RED_DYW,
		S_P1,
		S_P2,
		S_P3,
		S_PM,
		S_SUM,
		S_CMP,
		S_POW_INIT,
		S_POW_CHK,
		S_POW_RM,
		S_POW_RD,
		S_POW_SH,
		S_POW_XM,
		S_POW_XD,
		S_POW_END,
		S_FIN
	} state_t;

endpackage

// ===== rtl/rau_gcd.sv =====
// rau_gcd: binary gcd of two 64-bit values, one shift or subtract per cycle
// depends on rau_pkg
module rau_gcd
	import rau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic               busy_q;
	logic               done_q;
	logic [DW-1:0]      u_q;
	logic [DW-1:0]      v_q;
	logic [SHIFT_W-1:0] k_q;
	logic [DW-1:0]      g_q;
	logic               fin;

	assign fin = (u_q == '0) || (v_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && fin) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			u_q <= req.x;
			v_q <= req.y;
			k_q <= '0;
		end else if (busy_q) begin
			if (fin) begin
				g_q <= (u_q | v_q) << k_q;
			end else if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = g_q;

endmodule

// ===== rtl/rau_div.sv =====
// rau_div: restoring divider, 64-bit quotient, one quotient bit per cycle
// depends on rau_pkg
module rau_div
	import rau_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DW:0]          rem_q;
	logic [DW-1:0]        quo_q;
	logic [DW-1:0]        d_q;
	logic [DW:0]          shifted;
	logic [DW:0]          diff;
	logic                 ge;

	assign shifted = {rem_q[DW-1:0], quo_q[DW-1]};
	assign ge      = shifted >= {1'b0, d_q};
	assign diff    = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.x;
			d_q   <= req.y;
		end else if (busy_q) begin
			rem_q <= ge ? diff : shifted;
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = quo_q;

endmodule

// ===== rtl/rational_arithmetic_unit_core.sv =====
// rational_arithmetic_unit_core: top level of the rational arithmetic unit
// depends on rau_pkg, rau_gcd, rau_div
//
// One transaction at a time: a command is taken only while the unit is idle, and
// a finished result waits in an output register so the next command can be taken.
// Add, multiply and compare form cross products on one shared 33x33 multiplier (one
// product per cycle); add, multiply, negate and invert then bring the result to
// lowest terms with a binary gcd (one shift or subtract per cycle) and, when the
// gcd exceeds one, two divisions on the restoring divider. Power first reduces a,
// then runs up to eight square-and-multiply rounds of up to four products each.
// Unused opcodes, zero denominators and the inverse of zero go straight to the final
// state, and compare skips the gcd; the unit is idle again in the cycle after the
// result is loaded, and while the output register is stalled the result waits in
// the final state.
module rational_arithmetic_unit_core
	import rau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  rau_cmd_t cmd,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rau_rsp_t rsp
);

	state_t state_q, state_d;
	state_t ret_q;

	logic [2:0]         op_q;
	logic               an_q, bn_q;
	logic [31:0]        am_q, bm_q;
	logic [30:0]        ad_q, bd_q;
	logic               eneg_q, modd_q;
	logic [7:0]         m_q;
	logic               neg_q;
	logic [1:0]         st_q, rel_q;
	logic [DW-1:0]      x_q, y_q, g_q;
	logic signed [64:0] s1_q, s2_q;
	logic [32:0]        pm_q, pd_q;
	logic               rsp_valid_q;
	rau_rsp_t           rsp_q;

	logic [31:0]        a_mag, b_mag;
	logic               zden;
	logic               accept;
	logic [32:0]        mul_a, mul_b;
	logic [65:0]        prod;
	logic [32:0]        capped;
	logic signed [65:0] sum;
	logic [65:0]        sum_mag;
	logic               negeff, fits, can_emit;
	rau_rsp_t           emit;
	unit_req_t          gcd_req, div_req;
	unit_rsp_t          gcd_rsp, div_rsp;

	rau_gcd u_gcd (.clk(clk), .arst_n(arst_n), .req(gcd_req), .rsp(gcd_rsp));
	rau_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign accept   = cmd_valid && (state_q == S_IDLE);
	assign can_emit = !rsp_valid_q || !rsp_stall;
	assign a_mag    = cmd.a_num[31] ? (~cmd.a_num + 32'd1) : cmd.a_num;
	assign b_mag    = cmd.b_num[31] ? (~cmd.b_num + 32'd1) : cmd.b_num;
	assign zden     = (cmd.a_den == '0) || ((cmd.op == OP_ADD || cmd.op == OP_MUL
	                  || cmd.op == OP_CMP) && (cmd.b_den == '0));

	assign prod    = mul_a * mul_b;
	assign capped  = (prod > {33'd0, CAP_LIM}) ? CAP_SAT : prod[32:0];
	assign sum     = {s1_q[64], s1_q} + {s2_q[64], s2_q};
	assign sum_mag = sum[65] ? (~sum + 66'd1) : sum;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd.op > OP_CMP || zden) begin
						state_d = S_FIN;
					end else begin
						case (cmd.op)
							OP_ADD, OP_CMP: state_d = S_P1;
							OP_MUL:         state_d = S_PM;
							OP_INV:         state_d = (cmd.a_num == '0) ? S_FIN : S_RED_G;
							default:        state_d = S_RED_G;
						endcase
					end
				end
			end
			S_RED_G:    state_d = S_RED_GW;
			S_RED_GW: begin
				if (gcd_rsp.done) begin
					state_d = (gcd_rsp.value > DW'(1)) ? S_RED_DX : ret_q;
				end
			end
			S_RED_DX:   state_d = S_RED_DXW;
			S_RED_DXW:  if (div_rsp.done) state_d = S_RED_DY;
			S_RED_DY:   state_d = S_RED_DYW;
			S_RED_DYW:  if (div_rsp.done) state_d = ret_q;
			S_P1:       state_d = S_P2;
			S_P2:       state_d = (op_q == OP_CMP) ? S_CMP : S_P3;
			S_PM:       state_d = S_P3;
			S_P3:       state_d = (op_q == OP_ADD) ? S_SUM : S_RED_G;
			S_SUM:      state_d = S_RED_G;
			S_CMP:      state_d = S_FIN;
			S_POW_INIT: state_d = S_POW_CHK;
			S_POW_CHK: begin
				if (m_q == '0) state_d = S_POW_END;
				else if (m_q[0]) state_d = S_POW_RM;
				else state_d = S_POW_SH;
			end
			S_POW_RM:   state_d = S_POW_RD;
			S_POW_RD:   state_d = S_POW_SH;
			S_POW_SH:   state_d = ((m_q >> 1) != '0) ? S_POW_XM : S_POW_END;
			S_POW_XM:   state_d = S_POW_XD;
			S_POW_XD:   state_d = S_POW_CHK;
			S_POW_END:  state_d = S_FIN;
			S_FIN:      if (can_emit) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// unit requests and multiplier operands
	always_comb begin
		cmd_stall     = (state_q != S_IDLE);
		gcd_req.start = (state_q == S_RED_G);
		gcd_req.x     = x_q;
		gcd_req.y     = y_q;
		div_req.start = (state_q == S_RED_DX) || (state_q == S_RED_DY);
		div_req.x     = (state_q == S_RED_DX) ? x_q : y_q;
		div_req.y     = g_q;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			S_P1:     begin mul_a = {1'b0, am_q};       mul_b = {2'b0, bd_q}; end
			S_P2:     begin mul_a = {1'b0, bm_q};       mul_b = {2'b0, ad_q}; end
			S_PM:     begin mul_a = {1'b0, am_q};       mul_b = {1'b0, bm_q}; end
			S_P3:     begin mul_a = {2'b0, ad_q};       mul_b = {2'b0, bd_q}; end
			S_POW_RM: begin mul_a = x_q[32:0];          mul_b = pm_q;         end
			S_POW_RD: begin mul_a = y_q[32:0];          mul_b = pd_q;         end
			S_POW_XM: begin mul_a = pm_q;               mul_b = pm_q;         end
			S_POW_XD: begin mul_a = pd_q;               mul_b = pd_q;         end
			default:  begin mul_a = '0;                 mul_b = '0;           end
		endcase
	end

	// final range check and packing
	always_comb begin
		negeff = neg_q && (x_q != '0);
		fits   = (y_q >= DW'(1)) && (y_q <= RES_LIM - DW'(1))
		         && (negeff ? (x_q <= RES_LIM) : (x_q <= RES_LIM - DW'(1)));
		emit.relation = rel_q;
		if (st_q == ST_ZDEN) begin
			emit.res_num = '0;
			emit.res_den = '0;
			emit.status  = ST_ZDEN;
		end else if (!fits) begin
			emit.res_num = '0;
			emit.res_den = 31'd1;
			emit.status  = ST_OVF;
		end else begin
			emit.res_num = negeff ? (~x_q[31:0] + 32'd1) : x_q[31:0];
			emit.res_den = y_q[30:0];
			emit.status  = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_FIN;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				ret_q <= (cmd.op == OP_POW) ? S_POW_INIT : S_FIN;
			end
			if (state_q == S_FIN && can_emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= cmd.op;
					an_q   <= cmd.a_num[31];
					bn_q   <= cmd.b_num[31];
					am_q   <= a_mag;
					bm_q   <= b_mag;
					ad_q   <= cmd.a_den;
					bd_q   <= cmd.b_den;
					eneg_q <= cmd.exponent[7];
					m_q    <= cmd.exponent[7] ? (~cmd.exponent + 8'd1) : cmd.exponent;
					modd_q <= cmd.exponent[0];
					neg_q  <= 1'b0;
					st_q   <= ST_OK;
					rel_q  <= REL_EQ;
					x_q    <= '0;
					y_q    <= DW'(1);
					if (cmd.op <= OP_CMP) begin
						if (zden) begin
							st_q <= ST_ZDEN;
						end else begin
							case (cmd.op)
								OP_MUL: neg_q <= cmd.a_num[31] ^ cmd.b_num[31];
								OP_NEG: begin
									x_q   <= DW'(a_mag);
									y_q   <= DW'(cmd.a_den);
									neg_q <= !cmd.a_num[31];
								end
								OP_INV: begin
									if (cmd.a_num == '0) begin
										st_q <= ST_ZDEN;
									end else begin
										x_q   <= DW'(cmd.a_den);
										y_q   <= DW'(a_mag);
										neg_q <= cmd.a_num[31];
									end
								end
								OP_POW: begin
									x_q <= DW'(a_mag);
									y_q <= DW'(cmd.a_den);
								end
								default: ;
							endcase
						end
					end
				end
			end
			S_RED_GW:  if (gcd_rsp.done) g_q <= gcd_rsp.value;
			S_RED_DXW: if (div_rsp.done) x_q <= div_rsp.value;
			S_RED_DYW: if (div_rsp.done) y_q <= div_rsp.value;
			S_P1: s1_q <= an_q ? -$signed({1'b0, prod[63:0]}) : $signed({1'b0, prod[63:0]});
			S_P2: s2_q <= bn_q ? -$signed({1'b0, prod[63:0]}) : $signed({1'b0, prod[63:0]});
			S_PM: x_q  <= prod[63:0];
			S_P3: y_q  <= prod[63:0];
			S_SUM: begin
				neg_q <= sum[65];
				x_q   <= sum_mag[63:0];
			end
			S_CMP: begin
				if (s1_q == s2_q) rel_q <= REL_EQ;
				else if (s1_q < s2_q) rel_q <= REL_LT;
				else rel_q <= REL_GT;
			end
			S_POW_INIT: begin
				pm_q <= x_q[32:0];
				pd_q <= y_q[32:0];
				x_q  <= DW'(1);
				y_q  <= DW'(1);
			end
			S_POW_RM: x_q  <= DW'(capped);
			S_POW_RD: y_q  <= DW'(capped);
			S_POW_SH: m_q  <= m_q >> 1;
			S_POW_XM: pm_q <= capped;
			S_POW_XD: pd_q <= capped;
			S_POW_END: begin
				neg_q <= an_q && modd_q && (x_q != '0);
				if (eneg_q) begin
					if (x_q == '0) begin
						st_q <= ST_ZDEN;
					end else begin
						x_q <= y_q;
						y_q <= x_q;
					end
				end
			end
			S_FIN: if (can_emit) rsp_q <= emit;
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== verif/rational_arithmetic_unit_core_checker.sv =====
// rational_arithmetic_unit_core_checker: watches the command and result channels,
// predicts each result from the accepted command and compares; depends on rau_pkg
module rational_arithmetic_unit_core_checker
	import rau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  logic     cmd_stall,
	input  rau_cmd_t cmd,
	input  logic     rsp_valid,
	input  logic     rsp_stall,
	input  rau_rsp_t rsp,
	output int       fails,
	output int       pending
);

	typedef struct {
		bit              neg;
		longint unsigned mag;
		longint unsigned den;
	} ratio_t;

	localparam longint unsigned MAG_CAP = 64'd1 << 31;

	rau_rsp_t expected_rsp_q[$];

	function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	function automatic ratio_t reduce(ratio_t f);
		longint unsigned g;
		g = gcd64(f.mag, f.den);
		if (g != 0) begin
			f.mag = f.mag / g;
			f.den = f.den / g;
		end
		if (f.mag == 0)
			f.neg = 0;
		return f;
	endfunction

	function automatic ratio_t load(logic [31:0] n, logic [30:0] d);
		ratio_t f;
		f.neg = n[31];
		f.mag = f.neg ? (64'h1_0000_0000 - 64'(n)) : 64'(n);
		f.den = 64'(d);
		return reduce(f);
	endfunction

	function automatic longint sval(ratio_t f);
		return f.neg ? -longint'(f.mag) : longint'(f.mag);
	endfunction

	function automatic ratio_t from_signed(longint t, longint unsigned d);
		ratio_t f;
		f.neg = t < 0;
		f.mag = f.neg ? longint'(0) - t : t;
		f.den = d;
		return f;
	endfunction

	// saturating product: anything above 2^31 collapses to 2^31+1
	function automatic longint unsigned cap_mul(longint unsigned p, longint unsigned q);
		longint unsigned r;
		if (p > MAG_CAP) p = MAG_CAP + 1;
		if (q > MAG_CAP) q = MAG_CAP + 1;
		r = p * q;
		return (r > MAG_CAP) ? MAG_CAP + 1 : r;
	endfunction

	function automatic longint unsigned cap_pow(longint unsigned x, int unsigned m);
		longint unsigned r;
		r = 1;
		while (m != 0) begin
			if (m[0])
				r = cap_mul(r, x);
			m = m >> 1;
			if (m != 0)
				x = cap_mul(x, x);
		end
		return r;
	endfunction

	function automatic rau_rsp_t pack_result(ratio_t f, logic [1:0] st, logic [1:0] rel);
		rau_rsp_t o;
		bit fits;
		if (st == ST_OK) begin
			fits = f.den >= 1 && f.den <= MAG_CAP - 1 &&
				(f.neg ? f.mag <= MAG_CAP : f.mag <= MAG_CAP - 1);
			if (!fits) begin
				st = ST_OVF;
				f.neg = 0;
				f.mag = 0;
				f.den = 1;
			end
		end else if (st == ST_ZDEN) begin
			f.neg = 0;
			f.mag = 0;
			f.den = 0;
		end
		o.res_num  = f.neg ? 32'(longint'(0) - f.mag) : 32'(f.mag);
		o.res_den  = 31'(f.den);
		o.relation = rel;
		o.status   = st;
		return o;
	endfunction

	function automatic rau_rsp_t compute_fraction(rau_cmd_t c);
		ratio_t a, b, r;
		bit use_b, eneg;
		logic [1:0] rel;
		longint unsigned f, g1, g2, sw;
		longint t, l, h;
		int unsigned m;
		a = load(c.a_num, c.a_den);
		b = load(c.b_num, c.b_den);
		r.neg = 0;
		r.mag = 0;
		r.den = 1;
		rel = REL_EQ;
		use_b = c.op == OP_ADD || c.op == OP_MUL || c.op == OP_CMP;
		if (c.op > OP_CMP)
			return pack_result(r, ST_OK, REL_EQ);
		if (a.den == 0 || (use_b && b.den == 0))
			return pack_result(r, ST_ZDEN, REL_EQ);
		case (c.op)
			OP_ADD: begin
				f = gcd64(a.den, b.den);
				t = sval(a) * longint'(b.den / f) + sval(b) * longint'(a.den / f);
				r = reduce(from_signed(t, (a.den / f) * b.den));
			end
			OP_MUL: begin
				g1 = gcd64(a.mag, b.den);
				g2 = gcd64(b.mag, a.den);
				r.neg = a.neg != b.neg;
				r.mag = (a.mag / g1) * (b.mag / g2);
				r.den = (a.den / g2) * (b.den / g1);
				r = reduce(r);
			end
			OP_NEG: begin
				r = a;
				r.neg = !a.neg && a.mag != 0;
			end
			OP_INV: begin
				if (a.mag == 0)
					return pack_result(r, ST_ZDEN, REL_EQ);
				r.neg = a.neg;
				r.mag = a.den;
				r.den = a.mag;
			end
			OP_POW: begin
				eneg = c.exponent[7];
				// exponent taken as its raw byte so the magnitude stays in 0..128
				m = eneg ? 256 - int'($unsigned(c.exponent)) : int'($unsigned(c.exponent));
				r.mag = cap_pow(a.mag, m);
				r.den = cap_pow(a.den, m);
				r.neg = a.neg && m[0] && r.mag != 0;
				if (eneg) begin
					if (r.mag == 0)
						return pack_result(r, ST_ZDEN, REL_EQ);
					sw = r.mag;
					r.mag = r.den;
					r.den = sw;
				end
			end
			default: begin
				l = sval(a) * longint'(b.den);
				h = sval(b) * longint'(a.den);
				rel = (l == h) ? REL_EQ : ((l < h) ? REL_LT : REL_GT);
			end
		endcase
		return pack_result(r, ST_OK, rel);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rau_rsp_t want;
		if (!arst_n) begin
			fails = 0;
			pending = expected_rsp_q.size();
		end else begin
			if (cmd_valid && !cmd_stall)
				expected_rsp_q.push_back(compute_fraction(cmd));
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result transaction: num %0d den %0d rel %0d st %0d",
							rsp.res_num, rsp.res_den, rsp.relation, rsp.status);
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp !== want) begin
						fails++;
						if (fails <= 10)
							$display({"mismatch: expected num %0d den %0d rel %0d st %0d,",
								" got num %0d den %0d rel %0d st %0d"},
								want.res_num, want.res_den, want.relation, want.status,
								rsp.res_num, rsp.res_den, rsp.relation, rsp.status);
					end
				end
			end
			pending = expected_rsp_q.size();
		end
	end

endmodule

// ===== verif/rational_arithmetic_unit_core_test.sv =====
// rational_arithmetic_unit_core_test: stimulus, clock, reset and verdict for the core
// depends on rau_pkg, rational_arithmetic_unit_core and its checker
module rational_arithmetic_unit_core_test;
	import rau_pkg::*;

	localparam int RANDOM_ITEMS = 780;
	localparam int HOLD_CYCLES  = 600;

	logic     clk;
	logic     arst_n;
	logic     cmd_valid;
	logic     cmd_stall;
	rau_cmd_t cmd;
	logic     rsp_valid;
	logic     rsp_stall;
	rau_rsp_t rsp;
	int       fails;
	int       pending;

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;
	bit hold_used;
	int hold_left;

	rational_arithmetic_unit_core dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	rational_arithmetic_unit_core_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.fails(fails), .pending(pending)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	initial begin
		#30_000_000;
		$display("rational_arithmetic_unit_core test failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_request && !hold_used && hold_left == 0) begin
			hold_used <= 1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_fraction_op(logic [2:0] op, logic [31:0] an, logic [30:0] ad,
			logic [31:0] bn, logic [30:0] bd, logic [7:0] ex);
		rau_cmd_t c;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 0;
			@(posedge clk);
		end
		c.op = op;
		c.a_num = an;
		c.a_den = ad;
		c.b_num = bn;
		c.b_den = bd;
		c.exponent = ex;
		cmd <= c;
		cmd_valid <= 1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	function automatic logic [31:0] rand_num();
		case ($urandom_range(9))
			0, 1, 2: return 32'($urandom);
			3:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return 32'($signed($urandom_range(40)) - 20);
		endcase
	endfunction

	function automatic logic [30:0] rand_den();
		case ($urandom_range(49))
			0:             return 31'd0;
			1, 2, 3, 4, 5: return 31'($urandom);
			6:             return 31'h7fff_ffff;
			default:       return 31'($urandom_range(1, 30));
		endcase
	endfunction

	initial begin
		logic [2:0] op;
		logic [7:0] ex;
		arst_n = 0;
		cmd_valid = 0;
		cmd = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: each op, extremes and corner cases
		send_fraction_op(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3, 8'd0);
		send_fraction_op(OP_ADD, 32'h7fff_ffff, 31'd1, 32'd1, 31'd1, 8'd0);
		send_fraction_op(OP_ADD, 32'h8000_0000, 31'h7fff_ffff, 32'h8000_0000, 31'h7fff_fffe, 8'd0);
		send_fraction_op(OP_MUL, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1, 8'd0);
		send_fraction_op(OP_MUL, 32'd6, 31'd35, 32'd14, 31'd9, 8'd0);
		send_fraction_op(OP_NEG, 32'h8000_0000, 31'd1, 32'd0, 31'd1, 8'd0);
		send_fraction_op(OP_NEG, 32'd0, 31'd5, 32'd0, 31'd1, 8'd0);
		send_fraction_op(OP_INV, 32'hffff_fffd, 31'd7, 32'd0, 31'd1, 8'd0);
		send_fraction_op(OP_INV, 32'd0, 31'd7, 32'd0, 31'd1, 8'd0);
		send_fraction_op(OP_INV, 32'h8000_0000, 31'd1, 32'd0, 31'd1, 8'd0);
		send_fraction_op(OP_POW, 32'd0, 31'd1, 32'd0, 31'd1, 8'd0);
		send_fraction_op(OP_POW, 32'd0, 31'd3, 32'd0, 31'd1, 8'hff);
		send_fraction_op(OP_POW, 32'hfffffffe, 31'd3, 32'd0, 31'd1, 8'h80);
		send_fraction_op(OP_POW, 32'hfffffffe, 31'd3, 32'd0, 31'd1, 8'd5);
		send_fraction_op(OP_POW, 32'd2, 31'd1, 32'd0, 31'd1, 8'h7f);
		send_fraction_op(OP_POW, 32'hfffffffe, 31'd1, 32'd0, 31'd1, 8'd31);
		send_fraction_op(OP_CMP, 32'd1, 31'd3, 32'd2, 31'd6, 8'd0);
		send_fraction_op(OP_CMP, 32'h8000_0000, 31'd1, 32'h7fff_ffff, 31'h7fff_ffff, 8'd0);
		send_fraction_op(OP_CMP, 32'd5, 31'd2, 32'hffff_fffb, 31'd2, 8'd0);
		send_fraction_op(OP_ADD, 32'd4, 31'd8, 32'd3, 31'd0, 8'd0);
		send_fraction_op(OP_NEG, 32'd4, 31'd0, 32'd3, 31'd0, 8'd0);
		send_fraction_op(3'd6, 32'd4, 31'd8, 32'd3, 31'd9, 8'd1);
		send_fraction_op(3'd7, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff, 8'hff);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case (i)
				100: hold_request <= 1;
				120: hold_request <= 0;
				250: send_idle_pct = 72;
				400: begin
					send_idle_pct = 0;
					recv_stall_pct = 72;
				end
				550: begin
					send_idle_pct = 24;
					recv_stall_pct = 24;
				end
				default: ;
			endcase
			op = ($urandom_range(29) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
			ex = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($signed($urandom_range(16)) - 8);
			send_fraction_op(op, rand_num(), rand_den(), rand_num(), rand_den(), ex);
		end
		cmd_valid <= 0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (fails == 0)
			$display("rational_arithmetic_unit_core test passed");
		else
			$display("rational_arithmetic_unit_core test failed");
		$finish;
	end

endmodule

// ===== rational_arithmetic_unit_core.f =====
rtl/rau_pkg.sv
rtl/rau_gcd.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit_core.sv
verif/rational_arithmetic_unit_core_checker.sv
verif/rational_arithmetic_unit_core_test.sv
